### hdl/rstc_pkg.sv
// Package for the RPN token stack calculator: sizes, character codes,
// command and result types shared by the front end, queue and executor.
// No dependencies.
`default_nettype none

package rstc_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FIFO_DEPTH  = 4;
  localparam int FPTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] SEP_MAX = 8'd32;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_PLUS = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT  = 8'h2e;
  localparam logic [7:0] CH_S    = 8'h73;

  typedef enum logic [2:0] {
    KIND_VALUE     = 3'd0,
    KIND_DEPTH     = 3'd1,
    KIND_ELEMENT   = 3'd2,
    KIND_UNDERFLOW = 3'd3,
    KIND_OVERFLOW  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_ADD,
    OP_SUB,
    OP_DOT,
    OP_DOTS
  } op_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] value;
    logic               last;
  } out_item_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] num;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDB,
    ST_RDA,
    ST_POP,
    ST_DDEPTH,
    ST_DELEM,
    ST_ERR,
    ST_HALT
  } exec_state_t;

endpackage

`default_nettype wire

### hdl/rstc_front.sv
// Front end: splits the byte stream into tokens and classifies each token
// into a stack command. Depends on rstc_pkg.
`default_nettype none

module rstc_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rstc_pkg::in_item_t in_item,
  input  wire logic              accept,
  output logic                   cmd_valid,
  output rstc_pkg::cmd_t         cmd
);

  logic [1:0]  len_r, len_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [7:0]  second_r, second_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        alld_r, alld_nxt;
  logic        is_char;
  logic        is_digit;
  logic        tok_end;
  logic [3:0]  digit;

  always_comb begin
    is_char    = in_item.char_byte > rstc_pkg::SEP_MAX;
    is_digit   = (in_item.char_byte >= rstc_pkg::CH_ZERO) &&
                 (in_item.char_byte <= rstc_pkg::CH_NINE);
    digit      = 4'(in_item.char_byte - rstc_pkg::CH_ZERO);
    tok_end    = !is_char || in_item.end_of_input;
    len_nxt    = len_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    acc_nxt    = acc_r;
    alld_nxt   = alld_r;
    if (is_char) begin
      if (len_r == 2'd0) first_nxt = in_item.char_byte;
      if (len_r == 2'd1) second_nxt = in_item.char_byte;
      if (len_r != 2'd3) len_nxt = len_r + 2'd1;
      if (is_digit) begin
        acc_nxt = {acc_r[28:0], 3'b000} + {acc_r[30:0], 1'b0} + {28'd0, digit};
      end else begin
        alld_nxt = 1'b0;
      end
    end

    cmd.num   = acc_nxt;
    cmd.op    = rstc_pkg::OP_PUSH;
    cmd_valid = 1'b0;
    if (accept && tok_end && len_nxt != 2'd0) begin
      if (len_nxt == 2'd1 && first_nxt == rstc_pkg::CH_PLUS) begin
        cmd.op    = rstc_pkg::OP_ADD;
        cmd_valid = 1'b1;
      end else if (len_nxt == 2'd1 && first_nxt == rstc_pkg::CH_MINUS) begin
        cmd.op    = rstc_pkg::OP_SUB;
        cmd_valid = 1'b1;
      end else if (len_nxt == 2'd1 && first_nxt == rstc_pkg::CH_DOT) begin
        cmd.op    = rstc_pkg::OP_DOT;
        cmd_valid = 1'b1;
      end else if (len_nxt == 2'd2 && first_nxt == rstc_pkg::CH_DOT &&
                   second_nxt == rstc_pkg::CH_S) begin
        cmd.op    = rstc_pkg::OP_DOTS;
        cmd_valid = 1'b1;
      end else if (alld_nxt) begin
        cmd.op    = rstc_pkg::OP_PUSH;
        cmd_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= 2'd0;
      first_r  <= 8'd0;
      second_r <= 8'd0;
      acc_r    <= 32'd0;
      alld_r   <= 1'b1;
    end else if (accept) begin
      if (tok_end) begin
        len_r    <= 2'd0;
        first_r  <= 8'd0;
        second_r <= 8'd0;
        acc_r    <= 32'd0;
        alld_r   <= 1'b1;
      end else begin
        len_r    <= len_nxt;
        first_r  <= first_nxt;
        second_r <= second_nxt;
        acc_r    <= acc_nxt;
        alld_r   <= alld_nxt;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/rstc_fifo.sv
// Command queue between front end and executor.
// Depends on rstc_pkg.
`default_nettype none

module rstc_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_en,
  input  wire rstc_pkg::cmd_t wr_data,
  output logic                full,
  input  wire logic           rd_en,
  output rstc_pkg::cmd_t      rd_data,
  output logic                empty
);

  rstc_pkg::cmd_t                  mem_r [rstc_pkg::FIFO_DEPTH];
  logic [rstc_pkg::FPTR_W-1:0]     wptr_r, rptr_r;
  logic [rstc_pkg::FCNT_W-1:0]     cnt_r;
  logic                            do_wr, do_rd;

  assign full    = cnt_r == rstc_pkg::FCNT_W'(rstc_pkg::FIFO_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) wptr_r <= wptr_r + 1'b1;
      if (do_rd) rptr_r <= rptr_r + 1'b1;
      if (do_wr && !do_rd) cnt_r <= cnt_r + 1'b1;
      else if (do_rd && !do_wr) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

### hdl/rstc_exec.sv
// Executor: runs stack commands against the stack memory and drives the
// registered result channel. Depends on rstc_pkg.
`default_nettype none

module rstc_exec (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_empty,
  input  wire rstc_pkg::cmd_t cmd,
  output logic                cmd_pop,
  output logic                out_valid,
  output rstc_pkg::out_item_t out_item,
  input  wire logic           out_stall
);

  localparam int DW = rstc_pkg::DEPTH_W;
  localparam int AW = rstc_pkg::ADDR_W;

  logic [31:0]             mem [rstc_pkg::STACK_DEPTH];
  logic [31:0]             rd_data_r;
  logic [AW-1:0]           rd_addr;
  logic                    we;
  logic [AW-1:0]           wa;
  logic [31:0]             wd;

  rstc_pkg::exec_state_t   state_r, state_nxt;
  logic [DW-1:0]           depth_r, depth_nxt;
  logic [AW-1:0]           idx_r, idx_nxt;
  logic [31:0]             b_r, b_nxt;
  rstc_pkg::op_t           op_r, op_nxt;
  rstc_pkg::kind_t         err_r, err_nxt;
  logic                    out_valid_r, out_valid_nxt;
  rstc_pkg::out_item_t     out_item_r, out_item_nxt;
  logic                    can_load;
  logic [DW-1:0]           dm1, dm2;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign can_load  = !out_valid_r || !out_stall;
  assign dm1       = depth_r - DW'(1);
  assign dm2       = depth_r - DW'(2);

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    depth_nxt     = depth_r;
    idx_nxt       = idx_r;
    b_nxt         = b_r;
    op_nxt        = op_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    cmd_pop       = 1'b0;
    rd_addr       = '0;
    we            = 1'b0;
    wa            = depth_r[AW-1:0];
    wd            = cmd.num;

    unique case (state_r)
      rstc_pkg::ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          op_nxt  = cmd.op;
          unique case (cmd.op)
            rstc_pkg::OP_PUSH: begin
              if (depth_r == DW'(rstc_pkg::STACK_DEPTH)) begin
                err_nxt   = rstc_pkg::KIND_OVERFLOW;
                state_nxt = rstc_pkg::ST_ERR;
              end else begin
                we        = 1'b1;
                depth_nxt = depth_r + DW'(1);
              end
            end
            rstc_pkg::OP_ADD, rstc_pkg::OP_SUB: begin
              if (depth_r < DW'(2)) begin
                err_nxt   = rstc_pkg::KIND_UNDERFLOW;
                state_nxt = rstc_pkg::ST_ERR;
              end else begin
                rd_addr   = dm1[AW-1:0];
                state_nxt = rstc_pkg::ST_RDB;
              end
            end
            rstc_pkg::OP_DOT: begin
              if (depth_r == '0) begin
                err_nxt   = rstc_pkg::KIND_UNDERFLOW;
                state_nxt = rstc_pkg::ST_ERR;
              end else begin
                rd_addr   = dm1[AW-1:0];
                state_nxt = rstc_pkg::ST_POP;
              end
            end
            rstc_pkg::OP_DOTS: begin
              state_nxt = rstc_pkg::ST_DDEPTH;
            end
            default: state_nxt = rstc_pkg::ST_IDLE;
          endcase
        end
      end
      rstc_pkg::ST_RDB: begin
        b_nxt     = rd_data_r;
        rd_addr   = dm2[AW-1:0];
        state_nxt = rstc_pkg::ST_RDA;
      end
      rstc_pkg::ST_RDA: begin
        we        = 1'b1;
        wa        = dm2[AW-1:0];
        wd        = (op_r == rstc_pkg::OP_ADD) ? rd_data_r + b_r : rd_data_r - b_r;
        depth_nxt = dm1;
        state_nxt = rstc_pkg::ST_IDLE;
      end
      rstc_pkg::ST_POP: begin
        rd_addr = dm1[AW-1:0];
        if (can_load) begin
          out_valid_nxt      = 1'b1;
          out_item_nxt.kind  = rstc_pkg::KIND_VALUE;
          out_item_nxt.value = rd_data_r;
          out_item_nxt.last  = 1'b1;
          depth_nxt          = dm1;
          state_nxt          = rstc_pkg::ST_IDLE;
        end
      end
      rstc_pkg::ST_DDEPTH: begin
        rd_addr = '0;
        if (can_load) begin
          out_valid_nxt      = 1'b1;
          out_item_nxt.kind  = rstc_pkg::KIND_DEPTH;
          out_item_nxt.value = 32'(depth_r);
          out_item_nxt.last  = depth_r == '0;
          idx_nxt            = '0;
          state_nxt          = (depth_r == '0) ? rstc_pkg::ST_IDLE : rstc_pkg::ST_DELEM;
        end
      end
      rstc_pkg::ST_DELEM: begin
        rd_addr = idx_r;
        if (can_load) begin
          rd_addr            = idx_r + 1'b1;
          out_valid_nxt      = 1'b1;
          out_item_nxt.kind  = rstc_pkg::KIND_ELEMENT;
          out_item_nxt.value = rd_data_r;
          out_item_nxt.last  = DW'(idx_r) == dm1;
          idx_nxt            = idx_r + 1'b1;
          if (DW'(idx_r) == dm1) state_nxt = rstc_pkg::ST_IDLE;
        end
      end
      rstc_pkg::ST_ERR: begin
        if (can_load) begin
          out_valid_nxt      = 1'b1;
          out_item_nxt.kind  = err_r;
          out_item_nxt.value = '0;
          out_item_nxt.last  = 1'b1;
          state_nxt          = rstc_pkg::ST_HALT;
        end
      end
      rstc_pkg::ST_HALT: begin
        cmd_pop = !cmd_empty;
      end
      default: state_nxt = rstc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rstc_pkg::ST_IDLE;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    b_r        <= b_nxt;
    op_r       <= op_nxt;
    err_r      <= err_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

`default_nettype wire

### hdl/rpn_token_stack_calculator_top.sv
// Top level of the RPN token stack calculator: front end, command queue
// and executor. Depends on rstc_pkg, rstc_front, rstc_fifo, rstc_exec.
//
// Input channel (in_valid, in_stall, in_item): one text byte per item; bytes
// 0..32 separate tokens, end_of_input also ends a token. The front end takes
// one byte per cycle while the four-entry command queue has room.
// Output channel (out_valid, out_stall, out_item): results from a single
// output register; last marks the final result of the causing byte.
// Executor steps per command, limited by the single read port of the stack
// memory: push writes from idle; + and - read b (RDB), then a (RDA), and
// write the result; "." pops and outputs the top (POP); ".s" gives the depth
// (DDEPTH), then the elements (DELEM), one per cycle while not stalled.
// Reset (rst_n, synchronous) empties stack, token and queue and clears a
// halt. After an underflow or overflow result the executor drops all further
// commands until reset. A stall on the output holds the result register and
// backs up the executor, then the queue, then in_stall.
`default_nettype none

module rpn_token_stack_calculator_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire rstc_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output rstc_pkg::out_item_t      out_item
);

  logic           cmd_valid;
  rstc_pkg::cmd_t cmd_in;
  rstc_pkg::cmd_t cmd_out;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  logic           accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  rstc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .accept    (accept),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_in)
  );

  rstc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_valid),
    .wr_data (cmd_in),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (cmd_out),
    .empty   (q_empty)
  );

  rstc_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (q_empty),
    .cmd       (cmd_out),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

endmodule

`default_nettype wire

### hdl/rstc_checker.sv
// Port-level checks for the RPN token stack calculator, bound to the top.
// Depends on rstc_pkg and rpn_token_stack_calculator_top.
`default_nettype none

module rstc_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire rstc_pkg::out_item_t out_item
);

  logic is_err;
  assign is_err = (out_item.kind == rstc_pkg::KIND_UNDERFLOW) ||
                  (out_item.kind == rstc_pkg::KIND_OVERFLOW);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed under stall");

  a_err_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_err |-> out_item.value == 0 && out_item.last)
    else $error("error result not zero-valued and final");

  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && is_err |=> !out_valid)
    else $error("result after halt");

  a_empty_dump: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind == rstc_pkg::KIND_DEPTH && out_item.value == 0
      |-> out_item.last)
    else $error("empty dump not final");

endmodule

bind rpn_token_stack_calculator_top rstc_checker u_rstc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire
